FILE: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// shared constants and command and status codes for the chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_BYTES_DEF    = 8;
  localparam int BUCKETS_DEF      = 256;
  localparam int POOL_ENTRIES_DEF = 256;
  localparam int DATA_BITS_DEF    = 32;

  localparam int KEY_W   = 64;
  localparam int DIN_W   = 32;
  localparam int CFG_W   = 9;

  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_ENTER  = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_DELETE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_NOTFND = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

endpackage

FILE: rtl/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// separate-chaining hash table over a fixed entry pool
// ----------------------------------------------------------------------------
// One request at a time. A request passes through a bit-serial remainder of the
// key sum by the bucket count, taken into the bucket register, then the head
// read (S_HEAD, S_HEADW), a pool memory read and then a compare for each chain
// entry, one more read when the walk runs off the chain end, then the write-back
// states S_FREE and S_FREEW and the result register. The next request is
// accepted once the result has been taken. After reset a clearing pass sets
// every bucket head to null and fills the free stack; no request is accepted
// during it.
module chained_hash_table #(
  parameter int KEY_BYTES    = cht_pkg::KEY_BYTES_DEF,
  parameter int BUCKETS      = cht_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = cht_pkg::POOL_ENTRIES_DEF,
  parameter int DATA_BITS    = cht_pkg::DATA_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cht_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [cht_pkg::KEY_W-1:0] in_key,
  input  logic [cht_pkg::DIN_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic                     out_hit,
  output logic [cht_pkg::DIN_W-1:0] out_data_out
);
  import cht_pkg::*;

  localparam int PW  = $clog2(POOL_ENTRIES + 1);   // holds null
  localparam int PI  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int CW  = (BW > PI) ? BW : PI;
  localparam int KB  = KEY_BYTES * 8;
  localparam int DB  = (DATA_BITS < DIN_W) ? DATA_BITS : DIN_W;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'({(KEY_W+1){1'b1}} >> (KEY_W + 1 - KB));

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HEADW = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_FREEW = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [PW-1:0]   head_mem [BUCKETS];
  logic [KB-1:0]   key_mem  [POOL_ENTRIES];
  logic [DB-1:0]   data_mem [POOL_ENTRIES];
  logic [PW-1:0]   link_mem [POOL_ENTRIES];
  logic [PI-1:0]   free_mem [POOL_ENTRIES];

  logic [3:0]      state_r, state_nxt;
  logic [CW:0]     cnt_r;
  logic [CFG_W-1:0] bcnt_r;
  logic [PW-1:0]   fcnt_r;
  logic [1:0]      cmd_r;
  logic [KB-1:0]   key_r;
  logic [DB-1:0]   din_r;
  logic [BW-1:0]   bkt_r;
  logic [PW-1:0]   cur_r, prev_r, tail_r;
  logic [PW-1:0]   steps_r;
  logic [PW-1:0]   head_q;
  logic [KB-1:0]   key_q;
  logic [DB-1:0]   data_q;
  logic [PW-1:0]   link_q;
  logic [PI-1:0]   free_q;
  logic            ovalid_r;
  logic [1:0]      ost_r;
  logic            ohit_r;
  logic [DIN_W-1:0] odata_r;
  logic [KEY_W-1:0] key_m;
  logic [31:0]     ksum;
  logic [CFG_W-1:0] eff_bc;
  logic            mod_start, mod_done;
  logic [CFG_W-1:0] mod_rem;

  assign key_m = in_key & KEY_MASK;
  assign ksum  = key_m[31:0] + key_m[KEY_W-1:32];

  always_comb begin
    if (bcnt_r == '0) eff_bc = CFG_W'(1);
    else if (32'(bcnt_r) > BUCKETS) eff_bc = CFG_W'(BUCKETS);
    else eff_bc = bcnt_r;
  end

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign mod_start = in_valid && in_ready;

  cht_mod #(.DW(CFG_W)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(ksum),
    .divisor(eff_bc), .done(mod_done), .rem(mod_rem)
  );

  // pool, free stack and bucket head memory reads, registered
  always_ff @(posedge clk) begin
    key_q  <= key_mem[cur_r[PI-1:0]];
    data_q <= data_mem[cur_r[PI-1:0]];
    link_q <= link_mem[cur_r[PI-1:0]];
    free_q <= free_mem[PI'(fcnt_r - PW'(1))];
    head_q <= head_mem[bkt_r];
  end

  logic match, walk_end;
  assign match    = (key_q == key_r);
  assign walk_end = (cur_r == NIL) || (cur_r > NIL) || (steps_r == NIL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  if (cnt_r == (CW+1)'(((BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES) - 1))
                 state_nxt = S_IDLE;
      S_IDLE:  if (mod_start) state_nxt = S_MOD;
      S_MOD:   if (mod_done) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_HEADW;
      S_HEADW: state_nxt = S_READ;
      S_READ:  state_nxt = walk_end ? S_FREE : S_CMP;
      S_CMP:   state_nxt = match ? S_FREE : S_READ;
      S_FREE:  state_nxt = S_FREEW;
      S_FREEW: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  logic found_r;
  logic [PI-1:0] newe;
  // free stack entries are always valid pool indexes
  assign newe = free_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cnt_r    <= '0;
      bcnt_r   <= CFG_W'(256);
      fcnt_r   <= PW'(POOL_ENTRIES);
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bcnt_r <= cfg_wdata;
      if (state_r == S_INIT) cnt_r <= cnt_r + 1'b1;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      if (state_r == S_DONE) begin
        ovalid_r <= 1'b1;
        if (cmd_r == CMD_ENTER && !found_r && fcnt_r != '0 && fcnt_r <= NIL)
          fcnt_r <= fcnt_r - 1'b1;
        if (cmd_r == CMD_DELETE && found_r && fcnt_r < NIL)
          fcnt_r <= fcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_INIT) begin
      if (32'(cnt_r) < BUCKETS) head_mem[BW'(cnt_r)] <= NIL;
      if (32'(cnt_r) < POOL_ENTRIES) free_mem[PI'(cnt_r)] <= PI'(cnt_r);
    end
    unique case (state_r)
      S_IDLE: if (mod_start) begin
        cmd_r <= in_command;
        key_r <= key_m[KB-1:0];
        din_r <= in_data_in[DB-1:0];
      end
      S_MOD: bkt_r <= BW'(mod_rem);
      S_HEADW: begin
        cur_r   <= head_q;
        prev_r  <= NIL;
        tail_r  <= NIL;
        steps_r <= '0;
        found_r <= 1'b0;
      end
      S_CMP: if (match) found_r <= 1'b1;
        else begin
          prev_r  <= cur_r;
          tail_r  <= cur_r;
          cur_r   <= link_q;
          steps_r <= steps_r + 1'b1;
        end
      S_FREEW: begin
        ost_r   <= ST_OK;
        ohit_r  <= 1'b0;
        odata_r <= '0;
        unique case (cmd_r)
          CMD_FIND: if (found_r) begin
              ohit_r <= 1'b1;
              odata_r <= DIN_W'(data_q);
            end else ost_r <= ST_NOTFND;
          CMD_ENTER: if (found_r) ost_r <= ST_EXISTS;
            else if (fcnt_r == '0 || fcnt_r > NIL) ost_r <= ST_FULL;
            else begin
              key_mem[newe]  <= key_r;
              data_mem[newe] <= din_r;
              link_mem[newe] <= NIL;
              if (tail_r < NIL) link_mem[tail_r[PI-1:0]] <= PW'(newe);
              else head_mem[bkt_r] <= PW'(newe);
            end
          CMD_UPDATE: if (found_r) data_mem[cur_r[PI-1:0]] <= din_r;
            else ost_r <= ST_NOTFND;
          default: if (found_r) begin
              if (prev_r < NIL) link_mem[prev_r[PI-1:0]] <= link_q;
              else head_mem[bkt_r] <= link_q;
              if (fcnt_r < NIL) free_mem[PI'(fcnt_r)] <= cur_r[PI-1:0];
            end else ost_r <= ST_NOTFND;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid    = ovalid_r;
  assign out_status   = ost_r;
  assign out_hit      = ohit_r;
  assign out_data_out = odata_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= NIL) else $error("free count overflow");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == ST_OK)) else $error("hit with error");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> ovalid_r) else $error("result lost");
endmodule

FILE: rtl/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod
// iterative remainder of a 32-bit sum by the bucket count, one bit a cycle
// ----------------------------------------------------------------------------
module cht_mod #(
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);
  logic [31:0]   quo_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] div_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW+1:0] trial;
  logic [DW:0]   shifted;

  assign shifted = {rem_r[DW-1:0], quo_r[31]};
  assign trial   = {1'b0, shifted} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[30:0], 1'b0};
      if (!trial[DW+1]) rem_r <= trial[DW:0];
      else              rem_r <= shifted;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[DW-1:0];
endmodule

FILE: tb/sv/chained_hash_table_tb.sv
// ----------------------------------------------------------------------------
// chained_hash_table_tb
// Drives find, enter, update and delete requests into the chained hash table
// and checks every response against a predictor that keeps its own copy of
// the bucket heads, entry pool and free stack. The bucket count changes
// between phases, including zero, one, saturated values and a random value.
// The pool is also driven to full. Both sides idle in random bursts, and the
// receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;
  import cht_pkg::*;

  localparam int NBUCK   = BUCKETS_DEF;
  localparam int NPOOL   = POOL_ENTRIES_DEF;
  localparam int NIL     = NPOOL;
  localparam int WD_MAX  = 6000;
  localparam int NKEYS   = 48;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [DIN_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [DIN_W-1:0] dout;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_FIND;
  logic [KEY_W-1:0] in_key = '0;
  logic [DIN_W-1:0] in_data_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_hit;
  logic [DIN_W-1:0] out_data_out;

  chained_hash_table DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_key(in_key), .in_data_in(in_data_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_hit(out_hit), .out_data_out(out_data_out)
  );

  always #6 clk = ~clk;

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  logic [KEY_W-1:0] key_set[NKEYS];
  logic [KEY_W-1:0] fill_keys[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int hold_requests = 0;

  // table mirror
  logic [CFG_W-1:0] tbl_buckets;
  int               tbl_heads[NBUCK];
  logic [KEY_W-1:0] tbl_keys[NPOOL];
  logic [DIN_W-1:0] tbl_data[NPOOL];
  int               tbl_links[NPOOL];
  int               tbl_free[NPOOL];
  int               tbl_free_cnt;

  function automatic int bucket_index(logic [KEY_W-1:0] k);
    logic [31:0] sum;
    int n;
    sum = k[31:0] + k[63:32];
    n = tbl_buckets;
    if (n == 0) n = 1;
    if (n > NBUCK) n = NBUCK;
    return int'(sum % n);
  endfunction

  function automatic response_t apply_request(request_t r);
    response_t res;
    int b, cur, prev, tail, found, steps, n, nx;
    res = '0;
    b = bucket_index(r.key);
    cur = tbl_heads[b];
    prev = NIL;
    tail = NIL;
    found = NIL;
    steps = 0;
    while (cur < NIL && steps < NPOOL && found == NIL) begin
      if (tbl_keys[cur] == r.key) begin
        found = cur;
      end else begin
        prev = cur;
        tail = cur;
        cur = tbl_links[cur];
        steps++;
      end
    end
    case (r.cmd)
      CMD_FIND: begin
        if (found < NIL) begin
          res.hit = 1'b1;
          res.dout = tbl_data[found];
        end else res.status = ST_NOTFND;
      end
      CMD_ENTER: begin
        if (found < NIL) res.status = ST_EXISTS;
        else if (tbl_free_cnt == 0) res.status = ST_FULL;
        else begin
          tbl_free_cnt--;
          n = tbl_free[tbl_free_cnt];
          tbl_keys[n] = r.key;
          tbl_data[n] = r.data;
          tbl_links[n] = NIL;
          if (tail < NIL) tbl_links[tail] = n;
          else tbl_heads[b] = n;
        end
      end
      CMD_UPDATE: begin
        if (found < NIL) tbl_data[found] = r.data;
        else res.status = ST_NOTFND;
      end
      default: begin
        if (found < NIL) begin
          nx = tbl_links[found];
          if (prev < NIL) tbl_links[prev] = nx;
          else tbl_heads[b] = nx;
          if (tbl_free_cnt < NPOOL) begin
            tbl_free[tbl_free_cnt] = found;
            tbl_free_cnt++;
          end
        end else res.status = ST_NOTFND;
      end
    endcase
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  // input side
  bit in_taken = 1'b0;
  int in_gap = 0;

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_resps.push_back(apply_request('{in_command, in_key, in_data_in}));
  end

  always @(negedge clk) begin
    request_t r;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          r = pending_reqs.pop_front();
          in_command <= r.cmd;
          in_key <= r.key;
          in_data_in <= r.data;
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  int out_gap = 0;
  int hold_served = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        report("unexpected transaction", {62'd0, out_status}, '0);
      end else begin
        want = expected_resps.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_hit !== want.hit) report("hit", out_hit, want.hit);
        if (out_data_out !== want.dout) report("data_out", out_data_out, want.dout);
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= WD_MAX) begin
      $display("chained_hash_table_tb: FAIL");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic push_req(logic [1:0] c, logic [KEY_W-1:0] k, logic [DIN_W-1:0] d);
    pending_reqs.push_back('{c, k, d});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_buckets(logic [CFG_W-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    tbl_buckets = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_reqs(int count);
    int pick;
    logic [1:0] c;
    logic [KEY_W-1:0] k;
    logic [DIN_W-1:0] d;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) c = CMD_FIND;
      else if (pick < 65) c = CMD_ENTER;
      else if (pick < 80) c = CMD_UPDATE;
      else c = CMD_DELETE;
      if ($urandom_range(0, 9) == 0) k = rand_key();
      else k = key_set[$urandom_range(0, NKEYS - 1)];
      pick = $urandom_range(0, 19);
      d = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
      push_req(c, k, d);
    end
  endtask

  initial begin
    tbl_buckets = 9'd256;
    for (int i = 0; i < NBUCK; i++) tbl_heads[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      tbl_keys[i] = '0;
      tbl_data[i] = '0;
      tbl_links[i] = NIL;
      tbl_free[i] = i;
    end
    tbl_free_cnt = NPOOL;
    for (int i = 0; i < NKEYS; i++) key_set[i] = rand_key();
    // a few keys share a bucket under the default count
    key_set[1] = {32'd10, 32'd502};
    key_set[2] = {32'd0, 32'd256};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    push_req(CMD_FIND, '0, '0);
    push_req(CMD_ENTER, '0, '1);
    push_req(CMD_FIND, '0, '0);
    push_req(CMD_ENTER, '0, 32'h1234);
    push_req(CMD_ENTER, '1, '0);
    push_req(CMD_ENTER, {32'd0, 32'd512}, 32'hA5A5_5A5A);
    push_req(CMD_ENTER, key_set[1], 32'h1);
    push_req(CMD_ENTER, key_set[2], 32'h2);
    push_req(CMD_FIND, key_set[2], '0);
    push_req(CMD_UPDATE, key_set[1], '1);
    push_req(CMD_FIND, key_set[1], '0);
    push_req(CMD_UPDATE, 64'h5555_5555_AAAA_AAAA, 32'h3);
    push_req(CMD_DELETE, '0, '0);
    push_req(CMD_FIND, {32'd0, 32'd512}, '0);
    push_req(CMD_DELETE, '0, '0);
    push_req(CMD_DELETE, key_set[1], '0);
    push_req(CMD_FIND, key_set[2], '0);
    push_req(CMD_FIND, '1, '0);
    push_req(CMD_UPDATE, '1, 32'hFFFF_0000);
    push_req(CMD_FIND, '1, '0);

    // one bucket: fill the pool until it reports full
    set_buckets(9'd1);
    for (int i = 0; i < NPOOL + 4; i++) begin
      fill_keys.push_back(rand_key());
      push_req(CMD_ENTER, fill_keys[i], $urandom());
    end
    push_req(CMD_ENTER, fill_keys[5], '0);
    push_req(CMD_FIND, fill_keys[NPOOL - 10], '0);
    push_req(CMD_DELETE, fill_keys[7], '0);
    push_req(CMD_ENTER, rand_key(), 32'h77);
    push_req(CMD_ENTER, rand_key(), 32'h78);
    drain();
    foreach (fill_keys[i]) push_req(CMD_DELETE, fill_keys[i], '0);

    set_buckets(9'd0);
    random_reqs(12);
    set_buckets(9'h1FF);
    random_reqs(12);
    set_buckets(9'd256);
    random_reqs(10);
    repeat (30) @(negedge clk);
    hold_requests++;
    random_reqs(12);
    set_buckets(9'd13);
    random_reqs(12);
    set_buckets(9'($urandom_range(1, 256)));
    idle_on = 1'b0;
    random_reqs(12);

    drain();
    repeat (600) @(negedge clk);
    if (errors == 0) $display("chained_hash_table_tb: PASS");
    else $display("chained_hash_table_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/cht_pkg.sv
rtl/cht_mod.sv
rtl/chained_hash_table.sv
tb/sv/chained_hash_table_tb.sv
